[design/obbsat_pkg.sv]
package obbsat_pkg;

  // Corners per box and candidate axes per pair
  localparam int NUM_CORNERS = 4;
  localparam int NUM_AXES    = 4;
  localparam int NUM_POINTS  = 2 * NUM_CORNERS;

  // Corner order inside a box
  localparam int CORNER_TL = 0;
  localparam int CORNER_BL = 1;
  localparam int CORNER_TR = 2;
  localparam int CORNER_BR = 3;

  // Pipeline depth from input register to result register
  localparam int NUM_STAGES = 5;

  // Load enables for the lane stages behind the input register
  typedef struct packed {
    logic mul;
    logic add;
    logic ext;
    logic cmp;
  } obbsat_en_t;

endpackage

[design/obb_overlap_separating_axis_unit.sv]
// Oriented-box overlap test by the separating axis theorem. Each input word
// carries two boxes of four corners, every corner packed {y, x} as signed
// fixed point of COORD_WIDTH bits per coordinate (x in the low bits; y bits
// above bit 31 read as zero). The result is overlapping = 1 unless one of
// the NUM_AXES edge axes (top-left to bottom-left and top-left to top-right
// of each box) shows a strict gap between the two projected intervals;
// touching boxes overlap. The pipeline has five register stages (corner
// unpack and axis subtract, multiply, add, min/max, gap compare), and
// out_valid rises once a taken word reaches the gap compare register; all
// stages are fully pipelined, with 64 multipliers of COORD_WIDTH by
// (COORD_WIDTH+1) bits in parallel, so one pair is taken every cycle unless
// the output stalls; a stall holds full stages and backs up to in_ready.
module obb_overlap_separating_axis_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] first_top_left,
  input  logic [31:0] first_bottom_left,
  input  logic [31:0] first_top_right,
  input  logic [31:0] first_bottom_right,
  input  logic [31:0] second_top_left,
  input  logic [31:0] second_bottom_left,
  input  logic [31:0] second_top_right,
  input  logic [31:0] second_bottom_right,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        overlapping
);

  localparam int NP = obbsat_pkg::NUM_POINTS;
  localparam int NC = obbsat_pkg::NUM_CORNERS;
  localparam int NA = obbsat_pkg::NUM_AXES;
  localparam int NS = obbsat_pkg::NUM_STAGES;

  logic [31:0]                   corner [NP];
  logic [31:0]                   y_raw [NP];
  logic signed [COORD_WIDTH-1:0] px_next [NP];
  logic signed [COORD_WIDTH-1:0] py_next [NP];
  logic signed [COORD_WIDTH-1:0] px [NP];
  logic signed [COORD_WIDTH-1:0] py [NP];
  logic signed [COORD_WIDTH:0]   ax [NA];
  logic signed [COORD_WIDTH:0]   ay [NA];
  logic [NS-1:0]                 stage_valid;
  logic [NS-1:0]                 stage_ready;
  logic [NA-1:0]                 sep;
  obbsat_pkg::obbsat_en_t        en;

  assign corner[0] = first_top_left;
  assign corner[1] = first_bottom_left;
  assign corner[2] = first_top_right;
  assign corner[3] = first_bottom_right;
  assign corner[4] = second_top_left;
  assign corner[5] = second_bottom_left;
  assign corner[6] = second_top_right;
  assign corner[7] = second_bottom_right;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    stage_ready[NS-1] = !stage_valid[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_ready = stage_ready[0];
  assign en.mul   = stage_ready[1] && stage_valid[0];
  assign en.add   = stage_ready[2] && stage_valid[1];
  assign en.ext   = stage_ready[3] && stage_valid[2];
  assign en.cmp   = stage_ready[4] && stage_valid[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // Unpack corners: x from the low bits, y from the bits just above
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      y_raw[i]   = corner[i] >> COORD_WIDTH;
      px_next[i] = corner[i][COORD_WIDTH-1:0];
      py_next[i] = y_raw[i][COORD_WIDTH-1:0];
    end
  end

  // Register corners and the NUM_AXES edge axes
  always_ff @(posedge clk) begin
    if (stage_ready[0] && in_valid) begin
      px <= px_next;
      py <= py_next;
      for (int b = 0; b < 2; b++) begin
        ax[2*b]   <= (COORD_WIDTH+1)'(px_next[b*NC+obbsat_pkg::CORNER_BL])
                   - (COORD_WIDTH+1)'(px_next[b*NC+obbsat_pkg::CORNER_TL]);
        ay[2*b]   <= (COORD_WIDTH+1)'(py_next[b*NC+obbsat_pkg::CORNER_BL])
                   - (COORD_WIDTH+1)'(py_next[b*NC+obbsat_pkg::CORNER_TL]);
        ax[2*b+1] <= (COORD_WIDTH+1)'(px_next[b*NC+obbsat_pkg::CORNER_TR])
                   - (COORD_WIDTH+1)'(px_next[b*NC+obbsat_pkg::CORNER_TL]);
        ay[2*b+1] <= (COORD_WIDTH+1)'(py_next[b*NC+obbsat_pkg::CORNER_TR])
                   - (COORD_WIDTH+1)'(py_next[b*NC+obbsat_pkg::CORNER_TL]);
      end
    end
  end

  // One lane per candidate axis
  for (genvar a = 0; a < NA; a++) begin : g_lane
    obbsat_axis_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .px  (px),
      .py  (py),
      .ax  (ax[a]),
      .ay  (ay[a]),
      .sep (sep[a])
    );
  end

  assign out_valid   = stage_valid[NS-1];
  assign overlapping = ~|sep;

  // An empty output stage never blocks the input
  a_empty_out_ready : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // A draining output keeps the whole pipeline moving
  a_drain_ready : assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A held result keeps its lane flags
  a_hold_sep : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sep))
    else $error("lane flags changed during output stall");

  // An accepted word shows up at the first stage
  a_enter : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid[0])
    else $error("accepted word lost at pipeline entry");

endmodule

[design/obbsat_axis_lane.sv]
// Project both boxes onto one axis and flag a separating gap.
module obbsat_axis_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  obbsat_pkg::obbsat_en_t        en,
  input  logic signed [COORD_WIDTH-1:0] px [obbsat_pkg::NUM_POINTS],
  input  logic signed [COORD_WIDTH-1:0] py [obbsat_pkg::NUM_POINTS],
  input  logic signed [COORD_WIDTH:0]   ax,
  input  logic signed [COORD_WIDTH:0]   ay,
  output logic                          sep
);

  localparam int PW = 2 * COORD_WIDTH + 1;  // one product
  localparam int SW = PW + 1;               // sum of two products
  localparam int NP = obbsat_pkg::NUM_POINTS;
  localparam int NC = obbsat_pkg::NUM_CORNERS;

  logic signed [PW-1:0] mx [NP];
  logic signed [PW-1:0] my [NP];
  logic signed [SW-1:0] proj [NP];
  logic signed [SW-1:0] lo [2];
  logic signed [SW-1:0] hi [2];
  logic signed [SW-1:0] lo_next [2];
  logic signed [SW-1:0] hi_next [2];
  logic signed [SW-1:0] lo_a, lo_b, hi_a, hi_b;

  // Multiply each coordinate by its axis component
  always_ff @(posedge clk) begin
    if (en.mul) begin
      for (int i = 0; i < NP; i++) begin
        mx[i] <= PW'(px[i]) * PW'(ax);
        my[i] <= PW'(py[i]) * PW'(ay);
      end
    end
  end

  // Add the two products into the raw dot product
  always_ff @(posedge clk) begin
    if (en.add) begin
      for (int i = 0; i < NP; i++) begin
        proj[i] <= SW'(mx[i]) + SW'(my[i]);
      end
    end
  end

  // Reduce four projections per box to min and max, two levels deep
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      lo_a = (proj[b*NC+1] < proj[b*NC])   ? proj[b*NC+1] : proj[b*NC];
      lo_b = (proj[b*NC+3] < proj[b*NC+2]) ? proj[b*NC+3] : proj[b*NC+2];
      hi_a = (proj[b*NC+1] > proj[b*NC])   ? proj[b*NC+1] : proj[b*NC];
      hi_b = (proj[b*NC+3] > proj[b*NC+2]) ? proj[b*NC+3] : proj[b*NC+2];
      lo_next[b] = (lo_b < lo_a) ? lo_b : lo_a;
      hi_next[b] = (hi_b > hi_a) ? hi_b : hi_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ext) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // Flag a strict gap between the intervals; touching counts as overlap
  always_ff @(posedge clk) begin
    if (en.cmp) begin
      sep <= (lo[0] > hi[1]) || (hi[0] < lo[1]);
    end
  end

endmodule

[sim/tb_obb_overlap_separating_axis_unit.sv]
module tb_obb_overlap_separating_axis_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = 16;
  localparam int STUCK_LIMIT = 2000;

  typedef logic [obbsat_pkg::NUM_CORNERS-1:0][31:0] box_t;
  typedef logic [obbsat_pkg::NUM_POINTS-1:0][31:0] pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] first_top_left = '0;
  logic [31:0] first_bottom_left = '0;
  logic [31:0] first_top_right = '0;
  logic [31:0] first_bottom_right = '0;
  logic [31:0] second_top_left = '0;
  logic [31:0] second_bottom_left = '0;
  logic [31:0] second_top_right = '0;
  logic [31:0] second_bottom_right = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        overlapping;

  bit overlap_q[$];
  bit idling = 1'b1;
  int error_count = 0;
  int stuck_cycles = 0;
  int hold_cycles = 0;

  obb_overlap_separating_axis_unit #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_top_left(first_top_left),
    .first_bottom_left(first_bottom_left),
    .first_top_right(first_top_right),
    .first_bottom_right(first_bottom_right),
    .second_top_left(second_top_left),
    .second_bottom_left(second_bottom_left),
    .second_top_right(second_top_right),
    .second_bottom_right(second_bottom_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .overlapping(overlapping)
  );

  always #10 clk = ~clk;

  // Pick a gap length: mostly none or short, a few long
  function automatic int pause_len();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pack one corner as {y, x}
  function automatic logic [31:0] corner_word(int x, int y);
    logic [63:0] mask;
    logic [63:0] w;
    mask = (64'd1 << COORD_W) - 64'd1;
    w = ((64'(y) & mask) << COORD_W) | (64'(x) & mask);
    return w[31:0];
  endfunction

  // Extract one signed coordinate starting at bit pos
  function automatic longint coord_at(logic [31:0] w, int pos);
    logic [63:0] t;
    t = ({32'b0, w} >> pos) & ((64'd1 << COORD_W) - 64'd1);
    if (t[COORD_W-1]) return $signed(t) - (64'sd1 <<< COORD_W);
    return $signed(t);
  endfunction

  // Separating axis test over the NUM_AXES edge axes of both boxes
  function automatic bit boxes_overlap(pair_t p);
    longint cx[obbsat_pkg::NUM_POINTS];
    longint cy[obbsat_pkg::NUM_POINTS];
    longint ax[obbsat_pkg::NUM_AXES];
    longint ay[obbsat_pkg::NUM_AXES];
    longint v, amin, amax, bmin, bmax;
    int base;
    for (int i = 0; i < obbsat_pkg::NUM_POINTS; i++) begin
      cx[i] = coord_at(p[i], 0);
      cy[i] = coord_at(p[i], COORD_W);
    end
    for (int b = 0; b < 2; b++) begin
      base = b * obbsat_pkg::NUM_CORNERS;
      ax[2*b]   = cx[base+obbsat_pkg::CORNER_BL] - cx[base+obbsat_pkg::CORNER_TL];
      ay[2*b]   = cy[base+obbsat_pkg::CORNER_BL] - cy[base+obbsat_pkg::CORNER_TL];
      ax[2*b+1] = cx[base+obbsat_pkg::CORNER_TR] - cx[base+obbsat_pkg::CORNER_TL];
      ay[2*b+1] = cy[base+obbsat_pkg::CORNER_TR] - cy[base+obbsat_pkg::CORNER_TL];
    end
    for (int a = 0; a < obbsat_pkg::NUM_AXES; a++) begin
      amin = 0; amax = 0; bmin = 0; bmax = 0;
      for (int i = 0; i < obbsat_pkg::NUM_POINTS; i++) begin
        v = cx[i] * ax[a] + cy[i] * ay[a];
        if (i == 0) begin
          amin = v; amax = v;
        end else if (i == obbsat_pkg::NUM_CORNERS) begin
          bmin = v; bmax = v;
        end else if (i < obbsat_pkg::NUM_CORNERS) begin
          if (v < amin) amin = v;
          if (v > amax) amax = v;
        end else begin
          if (v < bmin) bmin = v;
          if (v > bmax) bmax = v;
        end
      end
      if (amin > bmax || amax < bmin) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Axis-aligned box from (x0, y0) to (x1, y1)
  function automatic box_t aa_box(int x0, int y0, int x1, int y1);
    box_t b;
    b[obbsat_pkg::CORNER_TL] = corner_word(x0, y0);
    b[obbsat_pkg::CORNER_BL] = corner_word(x0, y1);
    b[obbsat_pkg::CORNER_TR] = corner_word(x1, y0);
    b[obbsat_pkg::CORNER_BR] = corner_word(x1, y1);
    return b;
  endfunction

  // Square rotated by 45 degrees around (cx, cy)
  function automatic box_t diamond(int cx, int cy, int r);
    box_t b;
    b[obbsat_pkg::CORNER_TL] = corner_word(cx, cy - r);
    b[obbsat_pkg::CORNER_BL] = corner_word(cx - r, cy);
    b[obbsat_pkg::CORNER_TR] = corner_word(cx + r, cy);
    b[obbsat_pkg::CORNER_BR] = corner_word(cx, cy + r);
    return b;
  endfunction

  // Rectangle along direction (dx, dy) with half lengths hx, hy
  function automatic box_t rot_rect(int cx, int cy, int dx, int dy, int hx, int hy);
    box_t b;
    b[obbsat_pkg::CORNER_TL] = corner_word(cx - hx*dx + hy*dy, cy - hx*dy - hy*dx);
    b[obbsat_pkg::CORNER_BL] = corner_word(cx - hx*dx - hy*dy, cy - hx*dy + hy*dx);
    b[obbsat_pkg::CORNER_TR] = corner_word(cx + hx*dx + hy*dy, cy + hx*dy - hy*dx);
    b[obbsat_pkg::CORNER_BR] = corner_word(cx + hx*dx - hy*dy, cy + hx*dy + hy*dx);
    return b;
  endfunction

  function automatic box_t point_box(int x, int y);
    return aa_box(x, y, x, y);
  endfunction

  // Present one word and hold it until taken
  task automatic send_pair(input pair_t p);
    int gap;
    bit taken;
    gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    first_top_left      <= p[obbsat_pkg::CORNER_TL];
    first_bottom_left   <= p[obbsat_pkg::CORNER_BL];
    first_top_right     <= p[obbsat_pkg::CORNER_TR];
    first_bottom_right  <= p[obbsat_pkg::CORNER_BR];
    second_top_left     <= p[obbsat_pkg::NUM_CORNERS+obbsat_pkg::CORNER_TL];
    second_bottom_left  <= p[obbsat_pkg::NUM_CORNERS+obbsat_pkg::CORNER_BL];
    second_top_right    <= p[obbsat_pkg::NUM_CORNERS+obbsat_pkg::CORNER_TR];
    second_bottom_right <= p[obbsat_pkg::NUM_CORNERS+obbsat_pkg::CORNER_BR];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    overlap_q.push_back(boxes_overlap(p));
  endtask

  task automatic send_boxes(input box_t a, input box_t b);
    send_pair({b, a});
  endtask

  // Touching, gapped, rotated, degenerate and extreme boxes
  task automatic test_directed();
    send_boxes(aa_box(-256, -256, 256, 256), aa_box(-256, -256, 256, 256));
    send_boxes(aa_box(0, 0, 100, 100), aa_box(101, 0, 200, 100));
    send_boxes(aa_box(0, 0, 100, 100), aa_box(100, 0, 200, 100));
    send_boxes(aa_box(0, 0, 100, 100), aa_box(0, 100, 100, 200));
    send_boxes(aa_box(0, 0, 100, 100), aa_box(0, 101, 100, 200));
    send_boxes(diamond(0, 0, 100), aa_box(60, 60, 120, 120));
    send_boxes(diamond(0, 0, 100), aa_box(40, 40, 120, 120));
    send_boxes(aa_box(60, 60, 120, 120), diamond(0, 0, 100));
    send_boxes(aa_box(50, 50, 120, 120), diamond(0, 0, 100));
    // zero-length axes
    send_boxes(point_box(50, 50), aa_box(0, 0, 100, 100));
    send_boxes(point_box(150, 50), aa_box(0, 0, 100, 100));
    send_boxes(point_box(7, -7), point_box(7, -7));
    send_boxes(point_box(-300, 20), point_box(300, -20));
    // field extremes
    send_pair('0);
    send_pair('1);
    send_boxes(aa_box(-32768, -32768, 32767, 32767), point_box(32767, 32767));
    send_boxes(aa_box(-32768, -32768, -32768, 32767), aa_box(32767, -32768, 32767, 32767));
    send_boxes(aa_box(32767, 32767, -32768, -32768), aa_box(-32768, 32767, 32767, -32768));
    send_boxes(rot_rect(0, 0, 3, 4, 30, 10), rot_rect(200, 0, -4, 3, 20, 15));
  endtask

  // Rotated rectangles near each other, plus boxes touching or one unit apart
  task automatic test_random_rects(input int count);
    int cx, cy, w, h, step, span;
    for (int n = 0; n < count; n++) begin
      span = ($urandom_range(0, 9) == 0) ? 16000 : 2000;
      cx = $urandom_range(0, 2*span) - span;
      cy = $urandom_range(0, 2*span) - span;
      if ($urandom_range(0, 9) < 7) begin
        send_boxes(
          rot_rect(cx, cy, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                   $urandom_range(0, 40), $urandom_range(0, 40)),
          rot_rect(cx + $urandom_range(0, 3000) - 1500, cy + $urandom_range(0, 3000) - 1500,
                   $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                   $urandom_range(0, 40), $urandom_range(0, 40)));
      end else begin
        w = $urandom_range(1, 500);
        h = $urandom_range(1, 500);
        step = $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1)
          send_boxes(aa_box(cx, cy, cx + w, cy + h),
                     aa_box(cx + w + step, cy - 5, cx + 2*w, cy + h + 5));
        else
          send_boxes(aa_box(cx, cy, cx + w, cy + h),
                     aa_box(cx - 5, cy + h + step, cx + w + 5, cy + 2*h));
      end
    end
  endtask

  // Arbitrary corner words, not rectangles at all
  task automatic test_random_words(input int count);
    pair_t p;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < obbsat_pkg::NUM_POINTS; i++) begin
        if ($urandom_range(0, 1) == 1)
          p[i] = $urandom();
        else
          p[i] = corner_word($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300);
      end
      send_pair(p);
    end
  endtask

  // Full rate on both sides
  task automatic test_back_to_back(input int count);
    idling = 1'b0;
    test_random_rects(count / 2);
    test_random_words(count - count / 2);
    idling = 1'b1;
  endtask

  // Drive out_ready with random stalls
  always @(posedge clk) begin : drive_out_ready
    int g;
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      g = pause_len();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready   <= 1'b0;
        hold_cycles <= g - 1;
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(negedge clk) begin : check_result
    bit want_overlap;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (overlap_q.size() == 0) begin
        $error("overlapping: expected none, actual %0b", overlapping);
        error_count++;
      end else begin
        want_overlap = overlap_q.pop_front();
        if (overlapping !== want_overlap) begin
          $error("overlapping: expected %0b, actual %0b", want_overlap, overlapping);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_obb_overlap_separating_axis_unit NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_rects(180);
    test_back_to_back(60);
    test_random_words(80);
    test_random_rects(70);
    in_valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (obbsat_pkg::NUM_STAGES + 10) @(posedge clk);
    if (error_count == 0)
      $display("tb_obb_overlap_separating_axis_unit OK");
    else
      $display("tb_obb_overlap_separating_axis_unit NOT OK");
    $finish;
  end

endmodule
